[rtl/core/bct_pkg.sv]
`timescale 1ns / 1ps
package bct_pkg;

  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 8;
  localparam int CENT_BITS  = COORD_BITS + FRAC_BITS;
  localparam int RUN_W      = COORD_BITS + 1;
  localparam int SUM_W      = 2 * COORD_BITS;
  localparam int GAP_W      = 9;
  localparam int CFG_W      = 11;

  localparam logic [1:0] REG_MAX_GAP       = 2'd0;
  localparam logic [1:0] REG_COLUMN_STRIDE = 2'd1;
  localparam logic [1:0] REG_ROW_WIDTH     = 2'd2;

  typedef struct packed {
    logic       pixel_on;
    logic [9:0] column;
    logic [9:0] row_index;
    logic       frame_start;
  } px_in_t;

  typedef struct packed {
    logic [3:0]  blob_index;
    logic [17:0] centroid_x;
    logic [17:0] centroid_y;
    logic [9:0]  blob_rows;
    logic [4:0]  blob_total;
    logic        opened_new;
    logic        table_full;
  } blob_out_t;

  typedef struct packed {
    logic [CENT_BITS-1:0]  x;
    logic [CENT_BITS-1:0]  y;
    logic [RUN_W-1:0]      w;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] rows;
  } blob_ent_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MOD, ST_MOD_W, ST_PIX, ST_XR, ST_XR_W, ST_SCAN_RD, ST_SCAN_CHK,
    ST_MRG_X, ST_MRG_Y, ST_SHIFT_RD, ST_SHIFT_WR,
    ST_DECIDE, ST_MUL, ST_UPD_X, ST_UPD_X_W, ST_UPD_Y, ST_UPD_Y_W, ST_WB,
    ST_EMIT, ST_DONE
  } state_t;

endpackage

[rtl/core/bct_div.sv]
`timescale 1ns / 1ps
module bct_div #(
  parameter int DIVD_W = 30,
  parameter int DVS_W  = 11,
  parameter int STEP_W = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DVS_W-1:0]  divisor,
  input  logic [STEP_W-1:0] steps,
  output logic              busy,
  output logic [DIVD_W-1:0] quotient,
  output logic [DVS_W-1:0]  remainder
);

  localparam logic [STEP_W-1:0] FULL = STEP_W'(DIVD_W);

  logic [STEP_W-1:0] cnt;
  logic [DIVD_W-1:0] q;
  logic [DVS_W-1:0]  r;
  logic [DVS_W-1:0]  d;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;

  // restoring division, one quotient bit per cycle
  assign trial = {r, q[DIVD_W-1]};
  assign diff  = trial - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= steps;
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // dividend sits right-aligned in `steps` bits; move it to the top
      q <= dividend << (FULL - steps);
      r <= '0;
      d <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, d}) begin
        r <= diff[DVS_W-1:0];
        q <= {q[DIVD_W-2:0], 1'b1};
      end else begin
        r <= trial[DVS_W-1:0];
        q <= {q[DIVD_W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = q;
  assign remainder = r;

endmodule

[rtl/core/run_based_blob_centroid_tracker_core.sv]
`timescale 1ns / 1ps
// channel  | direction | payload     | handshake
// in       | input     | px_in_t     | in_valid / in_stall
// out      | output    | blob_out_t  | out_valid / out_stall
// cfg      | input     | write_data  | write_enable, reg_index
//
// A sampled pixel is first tested against the stride by a serial divide of the
// column. A closing run then divides for the run mean, scans each live blob,
// merges each further matching blob and shifts the entries above it down, and
// then updates a matched blob with two serial divides or writes a new one.
// rst is synchronous; the blob table needs no clearing pass.
// in_stall is high whenever a pixel is in work; a waiting result does not
// block the next pixel until that pixel itself has a result to deliver.
module run_based_blob_centroid_tracker_core import bct_pkg::*; #(
  parameter int BLOB_SLOTS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  px_in_t           in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output blob_out_t        out_data,
  input  logic             write_enable,
  input  logic [1:0]       reg_index,
  input  logic [CFG_W-1:0] write_data
);

  localparam int IDX_W  = (BLOB_SLOTS > 1) ? $clog2(BLOB_SLOTS) : 1;
  localparam int CNT_W  = $clog2(BLOB_SLOTS + 1);
  localparam int DIVD_W = CENT_BITS + COORD_BITS + 2;
  localparam int DVS_W  = COORD_BITS + 1;
  localparam int STEP_W = $clog2(DIVD_W + 1);
  localparam int MW     = CENT_BITS + 4;
  localparam int MRG_W  = CENT_BITS + 2;
  localparam int MP_W   = 2 * MRG_W;
  localparam logic [CNT_W-1:0]      SLOTS    = CNT_W'(BLOB_SLOTS);
  localparam logic [COORD_BITS-1:0] ROWS_MAX = '1;
  localparam logic [RUN_W-1:0]      RUN_CAP  = RUN_W'(1) << COORD_BITS;
  // reciprocal of three, exact for any merge sum below 2^(MRG_W+1)
  localparam logic [MRG_W-1:0]      THIRD    = MRG_W'(((64'd1 << (MRG_W + 1)) + 64'd2) / 64'd3);

  state_t state, state_next;

  logic [7:0]       max_gap;
  logic [4:0]       column_stride;
  logic [CFG_W-1:0] row_width;

  px_in_t              pix;
  logic [SUM_W-1:0]    run_sum;
  logic [RUN_W-1:0]    run_pix;
  logic [GAP_W-1:0]    gap_cnt;
  logic                run_open;
  logic                line_dropped;
  logic                row_end_r;
  logic                closing;
  logic [CNT_W-1:0]    live;
  logic [CNT_W-1:0]    scan_i;
  logic [CNT_W-1:0]    shift_j;
  logic                found;
  logic [CNT_W-1:0]    k_idx;
  logic [CENT_BITS-1:0] kx, ky, mx, my, xr, res_x, res_y;
  logic [RUN_W-1:0]     kw;
  logic [COORD_BITS-1:0] krows, res_rows;
  logic [DIVD_W-1:0]    prodx, prody;
  logic                 opened, full_flag;

  blob_ent_t blob_mem [BLOB_SLOTS];
  blob_ent_t rd_q;
  logic             mem_re, mem_we;
  logic [IDX_W-1:0] mem_raddr, mem_waddr;
  blob_ent_t        mem_wdata;

  logic              div_start, div_busy;
  logic [DIVD_W-1:0] div_dividend, div_q;
  logic [DVS_W-1:0]  div_divisor, div_r;
  logic [STEP_W-1:0] div_steps;

  logic [7:0] glim;
  logic [4:0] stride_e;
  logic       in_acc;
  logic       out_free;

  // pixel step
  logic                 row_end;
  logic                 ro_b, ld_b, ro_n, close_n;
  logic [SUM_W-1:0]     sum_b, sum_n;
  logic [RUN_W-1:0]     pix_b, pix_n;
  logic [GAP_W-1:0]     gap_b, gap_n;

  // match test
  logic signed [MW-1:0] xi_s, nh_s, g_s, bx_s, hw_s, lo_l, lo_r, hi_l, hi_r, rdiff;
  logic                 match;

  // merge at one-third weight
  logic [MRG_W-1:0]     mrg_sum;
  logic [MP_W-1:0]      mrg_prod;
  logic [CENT_BITS-1:0] mrg_q;

  blob_out_t out_next;

  assign glim     = (max_gap == 8'd0) ? 8'd1 : max_gap;
  assign stride_e = (column_stride == 5'd0) ? 5'd1 : column_stride;
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  bct_div #(.DIVD_W(DIVD_W), .DVS_W(DVS_W), .STEP_W(STEP_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .steps(div_steps), .busy(div_busy),
    .quotient(div_q), .remainder(div_r)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      blob_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= blob_mem[mem_raddr];
    end
  end

  always_comb begin
    row_end = ({2'b0, pix.column} + 12'(stride_e)) >= {1'b0, row_width};
    ro_b  = (pix.column == '0) ? 1'b0 : run_open;
    ld_b  = (pix.column == '0) ? 1'b0 : line_dropped;
    sum_b = (pix.column == '0) ? '0 : run_sum;
    pix_b = (pix.column == '0) ? '0 : run_pix;
    gap_b = (pix.column == '0) ? '0 : gap_cnt;
    ro_n  = ro_b;
    sum_n = sum_b;
    pix_n = pix_b;
    gap_n = gap_b;
    close_n = 1'b0;
    if (!ld_b) begin
      if (pix.pixel_on) begin
        ro_n  = 1'b1;
        gap_n = '0;
        if (pix_b < RUN_CAP) begin
          sum_n = sum_b + SUM_W'(pix.column);
          pix_n = pix_b + 1'b1;
        end
      end else if (ro_b) begin
        if (gap_b != '1) begin
          gap_n = gap_b + 1'b1;
        end
        if (gap_n >= GAP_W'(glim)) begin
          close_n = 1'b1;
        end
      end
      if (row_end && ro_n) begin
        close_n = 1'b1;
      end
    end
  end

  always_comb begin
    xi_s  = MW'(xr >> FRAC_BITS);
    nh_s  = MW'(run_pix >> 1);
    g_s   = MW'(glim);
    bx_s  = MW'(rd_q.x);
    hw_s  = MW'({rd_q.w, {(FRAC_BITS-1){1'b0}}});
    lo_l  = (xi_s + nh_s + g_s) <<< FRAC_BITS;
    lo_r  = bx_s - hw_s;
    hi_l  = (xi_s - nh_s) <<< FRAC_BITS;
    hi_r  = bx_s + hw_s + (g_s <<< FRAC_BITS);
    rdiff = MW'(pix.row_index) - MW'(rd_q.row);
    match = !(rdiff > g_s) && !(lo_l < lo_r) && !(hi_l > hi_r);
  end

  always_comb begin
    if (state == ST_MRG_Y) begin
      mrg_sum = MRG_W'({ky, 1'b0}) + MRG_W'(my);
    end else begin
      mrg_sum = MRG_W'({kx, 1'b0}) + MRG_W'(mx);
    end
    mrg_prod = MP_W'(mrg_sum) * MP_W'(THIRD);
    mrg_q    = CENT_BITS'(mrg_prod >> (MRG_W + 1));
  end

  always_comb begin
    out_next = '0;
    out_next.blob_total = 5'(live);
    if (full_flag) begin
      out_next.table_full = 1'b1;
    end else begin
      out_next.blob_index = 4'(k_idx);
      out_next.centroid_x = res_x;
      out_next.centroid_y = res_y;
      out_next.blob_rows  = res_rows;
      out_next.opened_new = opened;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = DVS_W'(1);
    div_steps    = STEP_W'(DIVD_W);
    mem_re       = 1'b0;
    mem_raddr    = scan_i[IDX_W-1:0];
    mem_we       = 1'b0;
    mem_waddr    = shift_j[IDX_W-1:0];
    mem_wdata    = rd_q;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if ({1'b0, pix.column} >= row_width) begin
          state_next = ST_IDLE;
        end else begin
          div_start    = 1'b1;
          div_dividend = DIVD_W'(pix.column);
          div_divisor  = DVS_W'(stride_e);
          div_steps    = STEP_W'(COORD_BITS);
          state_next   = ST_MOD_W;
        end
      end
      ST_MOD_W: begin
        if (!div_busy) begin
          state_next = (div_r == '0) ? ST_PIX : ST_IDLE;
        end
      end
      ST_PIX:   state_next = close_n ? ST_XR : ST_DONE;
      ST_XR: begin
        div_start    = 1'b1;
        div_dividend = DIVD_W'({run_sum, {FRAC_BITS{1'b0}}});
        div_divisor  = DVS_W'(run_pix);
        div_steps    = STEP_W'(SUM_W + FRAC_BITS);
        state_next   = ST_XR_W;
      end
      ST_XR_W: begin
        if (!div_busy) begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (scan_i < live) begin
          mem_re     = 1'b1;
          mem_raddr  = scan_i[IDX_W-1:0];
          state_next = ST_SCAN_CHK;
        end else begin
          state_next = ST_DECIDE;
        end
      end
      ST_SCAN_CHK: begin
        state_next = (match && found) ? ST_MRG_X : ST_SCAN_RD;
      end
      ST_MRG_X: state_next = ST_MRG_Y;
      ST_MRG_Y: state_next = ST_SHIFT_RD;
      ST_SHIFT_RD: begin
        // live already counts the removed entry out
        if (shift_j < live) begin
          mem_re     = 1'b1;
          mem_raddr  = IDX_W'(shift_j + 1'b1);
          state_next = ST_SHIFT_WR;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_SHIFT_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = shift_j[IDX_W-1:0];
        mem_wdata  = rd_q;
        state_next = ST_SHIFT_RD;
      end
      ST_DECIDE: begin
        if (found) begin
          state_next = ST_MUL;
        end else if (live >= SLOTS) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_WB;
        end
      end
      ST_MUL:   state_next = ST_UPD_X;
      ST_UPD_X: begin
        div_start    = 1'b1;
        div_dividend = prodx + DIVD_W'(xr);
        div_divisor  = DVS_W'(kw) + 1'b1;
        state_next   = ST_UPD_X_W;
      end
      ST_UPD_X_W: begin
        if (!div_busy) begin
          state_next = ST_UPD_Y;
        end
      end
      ST_UPD_Y: begin
        div_start    = 1'b1;
        div_dividend = prody + DIVD_W'({pix.row_index, {FRAC_BITS{1'b0}}});
        div_divisor  = DVS_W'(krows) + 1'b1;
        state_next   = ST_UPD_Y_W;
      end
      ST_UPD_Y_W: begin
        if (!div_busy) begin
          state_next = ST_WB;
        end
      end
      ST_WB: begin
        mem_we         = 1'b1;
        mem_waddr      = k_idx[IDX_W-1:0];
        mem_wdata.x    = res_x;
        mem_wdata.y    = res_y;
        mem_wdata.w    = run_pix;
        mem_wdata.row  = pix.row_index;
        mem_wdata.rows = res_rows;
        state_next     = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_gap       <= 8'd3;
      column_stride <= 5'd1;
      row_width     <= CFG_W'(640);
    end else if (write_enable) begin
      case (reg_index)
        REG_MAX_GAP:       max_gap       <= write_data[7:0];
        REG_COLUMN_STRIDE: column_stride <= write_data[4:0];
        REG_ROW_WIDTH:     row_width     <= write_data;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      live         <= '0;
      run_sum      <= '0;
      run_pix      <= '0;
      gap_cnt      <= '0;
      run_open     <= 1'b0;
      line_dropped <= 1'b0;
      out_valid    <= 1'b0;
      found        <= 1'b0;
      scan_i       <= '0;
      shift_j      <= '0;
      k_idx        <= '0;
      opened       <= 1'b0;
      full_flag    <= 1'b0;
      closing      <= 1'b0;
      row_end_r    <= 1'b0;
    end else begin
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc && in_data.frame_start) begin
            live         <= '0;
            run_sum      <= '0;
            run_pix      <= '0;
            gap_cnt      <= '0;
            run_open     <= 1'b0;
            line_dropped <= 1'b0;
          end
        end
        ST_PIX: begin
          run_sum      <= sum_n;
          run_pix      <= pix_n;
          gap_cnt      <= gap_n;
          run_open     <= ro_n;
          line_dropped <= ld_b;
          closing      <= close_n;
          row_end_r    <= row_end;
        end
        ST_XR_W: begin
          scan_i    <= '0;
          found     <= 1'b0;
          opened    <= 1'b0;
          full_flag <= 1'b0;
        end
        ST_SCAN_CHK: begin
          if (!match) begin
            scan_i <= scan_i + 1'b1;
          end else if (!found) begin
            found  <= 1'b1;
            k_idx  <= scan_i;
            scan_i <= scan_i + 1'b1;
          end
        end
        ST_MRG_Y: begin
          live    <= live - 1'b1;
          shift_j <= scan_i;
        end
        ST_SHIFT_WR: shift_j <= shift_j + 1'b1;
        ST_DECIDE: begin
          if (!found) begin
            if (live >= SLOTS) begin
              full_flag    <= 1'b1;
              line_dropped <= 1'b1;
            end else begin
              k_idx  <= live;
              live   <= live + 1'b1;
              opened <= 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (closing || row_end_r) begin
            run_sum  <= '0;
            run_pix  <= '0;
            gap_cnt  <= '0;
            run_open <= 1'b0;
          end
          if (row_end_r) begin
            line_dropped <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix <= in_data;
    end
    if (state == ST_EMIT && out_free) begin
      out_data <= out_next;
    end
    case (state)
      ST_XR_W: xr <= CENT_BITS'(div_q);
      ST_SCAN_CHK: begin
        if (match && !found) begin
          kx    <= rd_q.x;
          ky    <= rd_q.y;
          kw    <= rd_q.w;
          krows <= rd_q.rows;
        end
        mx <= rd_q.x;
        my <= rd_q.y;
      end
      ST_MRG_X: kx <= mrg_q;
      ST_MRG_Y: ky <= mrg_q;
      ST_DECIDE: begin
        // a fresh entry averages over nothing: the run itself
        res_x    <= xr;
        res_y    <= CENT_BITS'({pix.row_index, {FRAC_BITS{1'b0}}});
        res_rows <= COORD_BITS'(1);
      end
      ST_MUL: begin
        prodx    <= DIVD_W'(kx * kw);
        prody    <= DIVD_W'(ky * krows);
        res_rows <= (krows < ROWS_MAX) ? krows + 1'b1 : krows;
      end
      ST_UPD_X_W: begin
        if (!div_busy) begin
          res_x <= CENT_BITS'(div_q);
        end
      end
      ST_UPD_Y_W: begin
        if (!div_busy) begin
          res_y <= CENT_BITS'(div_q);
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/bct_checker.sv]
`timescale 1ns / 1ps
module bct_checker import bct_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input blob_out_t out_data
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a dropped run carries only the live count
  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.table_full |->
      out_data.blob_index == 4'd0 && out_data.centroid_x == 18'd0 &&
      out_data.blob_rows == 10'd0 && !out_data.opened_new)
    else $error("table-full result carries blob fields");

  a_open_one_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.opened_new |->
      out_data.blob_rows == 10'd1 && !out_data.table_full)
    else $error("new blob does not start with one run");

  a_update_live: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.table_full |->
      out_data.blob_total != 5'd0 && out_data.blob_rows != 10'd0)
    else $error("updated blob with empty table");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind run_based_blob_centroid_tracker_core bct_checker u_bct_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data(out_data)
);
